// ----- hw/rtl/i2cram_pkg.sv -----
package i2cram_pkg;

  typedef enum logic [3:0] {
    OP_END       = 4'd0,
    OP_START     = 4'd1,
    OP_SEND_DEV  = 4'd2,
    OP_SEND_DEVR = 4'd3,
    OP_SEND_REG  = 4'd4,
    OP_SEND_DATA = 4'd5,
    OP_ACK       = 4'd6,
    OP_ACK_IGN   = 4'd7,
    OP_READ      = 4'd8,
    OP_STOP      = 4'd9,
    OP_WAIT_W    = 4'd10,
    OP_WAIT_P    = 4'd11,
    OP_WAIT_C    = 4'd12
  } op_t;

  localparam logic [2:0] PROG_ABORT = 3'd5;
  localparam logic [3:0] PROG_LEN   = 4'd12;

  localparam logic [1:0] CFG_ACK_TIMEOUT = 2'd0;
  localparam logic [1:0] CFG_POST_WRITE  = 2'd1;
  localparam logic [1:0] CFG_PTR_READ    = 2'd2;
  localparam logic [1:0] CFG_POST_CMD    = 2'd3;

  // one queued word between the front and the sequencer
  typedef struct packed {
    logic       is_cmd;
    logic [2:0] kind;
    logic [7:0] dev_addr;
    logic [7:0] reg_addr;
    logic [7:0] wdata;
    logic [7:0] length;
    logic       sda_in;
  } req_t;

  // one result word
  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       rx_last;
    logic       done_res;
    logic       status;
    logic       busy_res;
  } res_t;

  function automatic op_t prog_op(input logic [2:0] p, input logic [3:0] ph);
    op_t o;
    o = OP_END;
    case (p)
      3'd0: begin
        case (ph)
          4'd0: o = OP_START;    4'd1: o = OP_SEND_DEV; 4'd2: o = OP_ACK;
          4'd3: o = OP_SEND_REG; 4'd4: o = OP_ACK_IGN;  4'd5: o = OP_SEND_DATA;
          4'd6: o = OP_ACK;      4'd7: o = OP_STOP;     4'd8: o = OP_WAIT_W;
          default: o = OP_END;
        endcase
      end
      3'd1: begin
        case (ph)
          4'd0: o = OP_START;    4'd1: o = OP_SEND_DEV;  4'd2: o = OP_ACK;
          4'd3: o = OP_SEND_REG; 4'd4: o = OP_ACK_IGN;   4'd5: o = OP_START;
          4'd6: o = OP_SEND_DEVR; 4'd7: o = OP_ACK_IGN;  4'd8: o = OP_READ;
          4'd9: o = OP_STOP;
          default: o = OP_END;
        endcase
      end
      3'd2: begin
        case (ph)
          4'd0: o = OP_START;    4'd1: o = OP_SEND_DEV;  4'd2: o = OP_ACK;
          4'd3: o = OP_SEND_REG; 4'd4: o = OP_ACK_IGN;   4'd5: o = OP_WAIT_P;
          4'd6: o = OP_START;    4'd7: o = OP_SEND_DEVR; 4'd8: o = OP_ACK_IGN;
          4'd9: o = OP_READ;     4'd10: o = OP_STOP;
          default: o = OP_END;
        endcase
      end
      3'd3: begin
        case (ph)
          4'd0: o = OP_START;    4'd1: o = OP_SEND_DEV; 4'd2: o = OP_ACK;
          4'd3: o = OP_SEND_REG; 4'd4: o = OP_ACK_IGN;  4'd5: o = OP_STOP;
          4'd6: o = OP_WAIT_C;
          default: o = OP_END;
        endcase
      end
      3'd4: begin
        case (ph)
          4'd0: o = OP_START; 4'd1: o = OP_SEND_DEVR; 4'd2: o = OP_ACK;
          4'd3: o = OP_READ;  4'd4: o = OP_STOP;      4'd5: o = OP_WAIT_C;
          default: o = OP_END;
        endcase
      end
      3'd5: begin
        case (ph)
          4'd0: o = OP_STOP;
          default: o = OP_END;
        endcase
      end
      default: o = OP_END;
    endcase
    return o;
  endfunction

endpackage

// ----- hw/rtl/i2cram_queue.sv -----
module i2cram_queue import i2cram_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  req_t wr_data,
  output logic full,
  input  logic rd_en,
  output req_t rd_data,
  output logic empty
);

  // two-entry queue between front and sequencer
  req_t       mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign rd_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr_en && !full) begin
      mem[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr_en && !full) wptr <= ~wptr;
      if (rd_en && !empty) rptr <= ~rptr;
      count <= count + {1'b0, wr_en && !full} - {1'b0, rd_en && !empty};
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (rst) (full && !rd_en) |=> full)
    else $error("queue lost a word");
  assert property (@(posedge clk) disable iff (rst) (empty && !wr_en) |=> empty)
    else $error("queue invented a word");

endmodule

// ----- hw/rtl/i2cram_seq.sv -----
module i2cram_seq import i2cram_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  ack_timeout,
  input  logic [15:0] post_write_wait,
  input  logic [16:0] pointer_read_wait,
  input  logic [15:0] post_cmd_wait,
  input  logic        req_valid,
  input  req_t        req,
  output logic        req_take,
  output logic        res_valid,
  output res_t        res,
  input  logic        res_stall
);

  logic        active;
  logic        failed;
  logic [2:0]  prog;
  logic [3:0]  phase;
  logic [3:0]  bit_count;
  logic [7:0]  shift_byte;
  logic [7:0]  bytes_left;
  logic [16:0] delay_count;
  logic [7:0]  poll_count;
  logic [7:0]  cmd_dev;
  logic [7:0]  cmd_reg;
  logic [7:0]  cmd_wdata;
  logic        scl_level;
  logic        sda_level;

  logic        active_next;
  logic        failed_next;
  logic [2:0]  prog_next;
  logic [3:0]  phase_next;
  logic [3:0]  bit_count_next;
  logic [7:0]  shift_byte_next;
  logic [7:0]  bytes_left_next;
  logic [16:0] delay_count_next;
  logic [7:0]  poll_count_next;
  logic [7:0]  cmd_dev_next;
  logic [7:0]  cmd_reg_next;
  logic [7:0]  cmd_wdata_next;
  logic        scl_next;
  logic        sda_next;
  logic [7:0]  rx_byte_w;
  logic        rx_valid_w;
  logic        rx_last_w;
  logic        done_w;
  logic [1:0]  r;
  logic        enter;
  op_t         op;
  logic [3:0]  ph_a;
  logic [3:0]  ph_b;
  op_t         op_a;
  op_t         op_b;
  logic [16:0] wlen_a;
  logic        skip_a;
  logic [16:0] wlen_b;
  logic        skip_b;

  // result register: taken whenever it is empty or being drained
  assign req_take = req_valid && (!res_valid || !res_stall);

  function automatic logic [16:0] wait_len(input op_t o, input logic [15:0] pw,
                                           input logic [16:0] pr, input logic [15:0] pc);
    logic [16:0] w;
    w = 17'd0;
    case (o)
      OP_WAIT_W: w = {1'b0, pw};
      OP_WAIT_P: w = pr;
      OP_WAIT_C: w = {1'b0, pc};
      default:   w = 17'd0;
    endcase
    return w;
  endfunction

  always_comb begin
    active_next      = active;
    failed_next      = failed;
    prog_next        = prog;
    phase_next       = phase;
    bit_count_next   = bit_count;
    shift_byte_next  = shift_byte;
    bytes_left_next  = bytes_left;
    delay_count_next = delay_count;
    poll_count_next  = poll_count;
    cmd_dev_next     = cmd_dev;
    cmd_reg_next     = cmd_reg;
    cmd_wdata_next   = cmd_wdata;
    scl_next         = scl_level;
    sda_next         = sda_level;
    rx_byte_w        = 8'd0;
    rx_valid_w       = 1'b0;
    rx_last_w        = 1'b0;
    done_w           = 1'b0;
    r                = 2'd0;
    enter            = 1'b0;
    op               = (phase < PROG_LEN) ? prog_op(prog, phase) : OP_END;

    if (req.is_cmd) begin
      if (!active && req.kind <= 3'd4) begin
        cmd_dev_next    = req.dev_addr;
        cmd_reg_next    = req.reg_addr;
        cmd_wdata_next  = req.wdata;
        prog_next       = req.kind;
        phase_next      = 4'd0;
        failed_next     = 1'b0;
        bytes_left_next = (req.kind == 3'd1) ? 8'd1 : req.length;
        enter           = 1'b1;
      end
    end else if (active) begin
      case (op)
        OP_START: begin
          scl_next = 1'b1;
          sda_next = (delay_count < 17'd4);
          if (delay_count >= 17'd7) r = 2'd1;
          else delay_count_next = delay_count + 17'd1;
        end
        OP_SEND_DEV, OP_SEND_DEVR, OP_SEND_REG, OP_SEND_DATA: begin
          sda_next = shift_byte[7];
          scl_next = (delay_count == 17'd2) || (delay_count == 17'd3);
          if (delay_count >= 17'd5) begin
            shift_byte_next  = {shift_byte[6:0], 1'b0};
            bit_count_next   = bit_count + 4'd1;
            delay_count_next = 17'd0;
            if (bit_count_next >= 4'd8) r = 2'd1;
          end else begin
            delay_count_next = delay_count + 17'd1;
          end
        end
        OP_ACK, OP_ACK_IGN: begin
          sda_next = 1'b1;
          scl_next = (delay_count != 17'd0);
          if (delay_count < 17'd2) delay_count_next = delay_count + 17'd1;
          else if (!req.sda_in) r = 2'd1;
          else if (poll_count >= ack_timeout) r = (op == OP_ACK) ? 2'd2 : 2'd1;
          else poll_count_next = poll_count + 8'd1;
        end
        OP_READ: begin
          if (bit_count < 4'd8) begin
            sda_next = 1'b1;
            if (delay_count < 17'd2) begin
              scl_next = 1'b0;
              delay_count_next = delay_count + 17'd1;
            end else begin
              scl_next = 1'b1;
              shift_byte_next  = {shift_byte[6:0], req.sda_in};
              bit_count_next   = bit_count + 4'd1;
              delay_count_next = 17'd0;
              if (bit_count == 4'd7) begin
                rx_byte_w  = shift_byte_next;
                rx_valid_w = 1'b1;
                rx_last_w  = (bytes_left == 8'd1);
              end
            end
          end else begin
            sda_next = !(bytes_left > 8'd1);
            scl_next = (delay_count >= 17'd2);
            if (delay_count < 17'd3) begin
              delay_count_next = delay_count + 17'd1;
            end else begin
              bytes_left_next  = bytes_left - 8'd1;
              bit_count_next   = 4'd0;
              delay_count_next = 17'd0;
              shift_byte_next  = 8'd0;
              if (bytes_left == 8'd1) r = 2'd1;
            end
          end
        end
        OP_STOP: begin
          scl_next = (delay_count >= 17'd4);
          sda_next = (delay_count >= 17'd5);
          if (delay_count >= 17'd8) r = 2'd1;
          else delay_count_next = delay_count + 17'd1;
        end
        OP_WAIT_W, OP_WAIT_P, OP_WAIT_C: begin
          if (delay_count != 17'd0) delay_count_next = delay_count - 17'd1;
          if (delay_count_next == 17'd0) r = 2'd1;
        end
        default: r = 2'd1;
      endcase
      if (r == 2'd2) begin
        failed_next = 1'b1;
        prog_next   = PROG_ABORT;
        phase_next  = 4'd0;
        enter       = 1'b1;
      end else if (r == 2'd1) begin
        phase_next = phase + 4'd1;
        enter      = 1'b1;
      end
    end

    // op entry: an empty wait or a read of zero length is skipped; no program
    // puts two of them in a row, the second look-ahead only guards that
    ph_a   = phase_next;
    ph_b   = phase_next + 4'd1;
    op_a   = (ph_a < PROG_LEN) ? prog_op(prog_next, ph_a) : OP_END;
    op_b   = (ph_b < PROG_LEN) ? prog_op(prog_next, ph_b) : OP_END;
    wlen_a = wait_len(op_a, post_write_wait, pointer_read_wait, post_cmd_wait);
    wlen_b = wait_len(op_b, post_write_wait, pointer_read_wait, post_cmd_wait);
    skip_a = ((op_a == OP_WAIT_W || op_a == OP_WAIT_P || op_a == OP_WAIT_C)
              && wlen_a == 17'd0) || (op_a == OP_READ && bytes_left_next == 8'd0);
    skip_b = ((op_b == OP_WAIT_W || op_b == OP_WAIT_P || op_b == OP_WAIT_C)
              && wlen_b == 17'd0) || (op_b == OP_READ && bytes_left_next == 8'd0);
    if (enter) begin
      if (skip_a) begin
        phase_next = ph_b;
        if (skip_b) phase_next = ph_b + 4'd1;
      end
      op = (phase_next < PROG_LEN) ? prog_op(prog_next, phase_next) : OP_END;
      delay_count_next = wait_len(op, post_write_wait, pointer_read_wait, post_cmd_wait);
      bit_count_next   = 4'd0;
      poll_count_next  = 8'd0;
      case (op)
        OP_SEND_DEV:  shift_byte_next = cmd_dev_next;
        OP_SEND_DEVR: shift_byte_next = cmd_dev_next + 8'd1;
        OP_SEND_REG:  shift_byte_next = cmd_reg_next;
        OP_SEND_DATA: shift_byte_next = cmd_wdata_next;
        default:      shift_byte_next = shift_byte_next;
      endcase
      if (op == OP_END) begin
        active_next = 1'b0;
        done_w      = !req.is_cmd;
      end else begin
        active_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      failed      <= 1'b0;
      prog        <= 3'd0;
      phase       <= 4'd0;
      bit_count   <= 4'd0;
      shift_byte  <= 8'd0;
      bytes_left  <= 8'd0;
      delay_count <= 17'd0;
      poll_count  <= 8'd0;
      cmd_dev     <= 8'd0;
      cmd_reg     <= 8'd0;
      cmd_wdata   <= 8'd0;
      scl_level   <= 1'b1;
      sda_level   <= 1'b1;
      res_valid   <= 1'b0;
    end else begin
      if (res_valid && !res_stall) res_valid <= 1'b0;
      if (req_take) begin
        active      <= active_next;
        failed      <= failed_next;
        prog        <= prog_next;
        phase       <= phase_next;
        bit_count   <= bit_count_next;
        shift_byte  <= shift_byte_next;
        bytes_left  <= bytes_left_next;
        delay_count <= delay_count_next;
        poll_count  <= poll_count_next;
        cmd_dev     <= cmd_dev_next;
        cmd_reg     <= cmd_reg_next;
        cmd_wdata   <= cmd_wdata_next;
        scl_level   <= scl_next;
        sda_level   <= sda_next;
        res_valid   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      res.scl      <= scl_next;
      res.sda_out  <= sda_next;
      res.rx_byte  <= rx_byte_w;
      res.rx_valid <= rx_valid_w;
      res.rx_last  <= rx_last_w;
      res.done_res <= done_w;
      res.status   <= done_w && failed_next;
      res.busy_res <= active_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
                   (res_valid && res.done_res) |-> !res.busy_res)
    else $error("busy with done");
  assert property (@(posedge clk) disable iff (rst)
                   (res_valid && !res.rx_valid) |-> !res.rx_last)
    else $error("last without byte");
  assert property (@(posedge clk) disable iff (rst)
                   (res_valid && res_stall) |=> res_valid)
    else $error("result dropped");

endmodule

// ----- hw/rtl/i2c_register_access_master.sv -----
// i2c register access master: bit-level bus sequencer stepped by tick words
// a word passes through the input queue and then the sequencer's result register
// on its way from acceptance to result; an output stall holds the result back
// throughput: one word per clock while out_stall is low; the sequencer steps once per word
// reset: synchronous active-high rst clears queue and sequencer, lines released,
// timeout 250, waits 200 / 100000 / 5000
module i2c_register_access_master import i2cram_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        req_type,
  input  logic [2:0]  kind,
  input  logic [7:0]  dev_addr,
  input  logic [7:0]  reg_addr,
  input  logic [7:0]  wdata,
  input  logic [7:0]  length,
  input  logic        sda_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        scl,
  output logic        sda_out,
  output logic [7:0]  rx_byte,
  output logic        rx_valid,
  output logic        rx_last,
  output logic        done_res,
  output logic        status,
  output logic        busy_res,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  // configuration registers
  logic [7:0]  ack_timeout;
  logic [15:0] post_write_wait;
  logic [16:0] pointer_read_wait;
  logic [15:0] post_cmd_wait;

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_timeout       <= 8'd250;
      post_write_wait   <= 16'd200;
      pointer_read_wait <= 17'd100000;
      post_cmd_wait     <= 16'd5000;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ACK_TIMEOUT: ack_timeout       <= cfg_data[7:0];
        CFG_POST_WRITE:  post_write_wait   <= cfg_data[15:0];
        CFG_PTR_READ:    pointer_read_wait <= cfg_data;
        CFG_POST_CMD:    post_cmd_wait     <= cfg_data[15:0];
        default:         ack_timeout       <= ack_timeout;
      endcase
    end
  end

  // front: pack the incoming word and queue it
  req_t q_in;
  req_t q_out;
  logic q_full;
  logic q_empty;
  logic take;
  res_t res;

  assign q_in = '{is_cmd: req_type, kind: kind, dev_addr: dev_addr, reg_addr: reg_addr,
                  wdata: wdata, length: length, sda_in: sda_in};
  assign in_stall = q_full;

  i2cram_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (in_valid),
    .wr_data (q_in),
    .full    (q_full),
    .rd_en   (take),
    .rd_data (q_out),
    .empty   (q_empty)
  );

  // back: bus sequencer with its result register
  i2cram_seq u_seq (
    .clk               (clk),
    .rst               (rst),
    .ack_timeout       (ack_timeout),
    .post_write_wait   (post_write_wait),
    .pointer_read_wait (pointer_read_wait),
    .post_cmd_wait     (post_cmd_wait),
    .req_valid         (!q_empty),
    .req               (q_out),
    .req_take          (take),
    .res_valid         (out_valid),
    .res               (res),
    .res_stall         (out_stall)
  );

  assign scl      = res.scl;
  assign sda_out  = res.sda_out;
  assign rx_byte  = res.rx_byte;
  assign rx_valid = res.rx_valid;
  assign rx_last  = res.rx_last;
  assign done_res = res.done_res;
  assign status   = res.status;
  assign busy_res = res.busy_res;

  assert property (@(posedge clk) disable iff (rst) (in_valid && in_stall) |=> in_valid)
    else $error("input word withdrawn while stalled");
  assert property (@(posedge clk) disable iff (rst) (out_valid && status) |-> done_res)
    else $error("status without done");
  assert property (@(posedge clk) disable iff (rst) (out_valid && rx_valid) |-> !done_res)
    else $error("byte on done word");

endmodule

// ----- test/i2c_register_access_master_check.sv -----
`timescale 1ns / 1ps

module i2c_register_access_master_check import i2cram_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        req_type,
  input  logic [2:0]  kind,
  input  logic [7:0]  dev_addr,
  input  logic [7:0]  reg_addr,
  input  logic [7:0]  wdata,
  input  logic [7:0]  length,
  input  logic        sda_in,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        scl,
  input  logic        sda_out,
  input  logic [7:0]  rx_byte,
  input  logic        rx_valid,
  input  logic        rx_last,
  input  logic        done_res,
  input  logic        status,
  input  logic        busy_res,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data,
  output int          failures,
  output int          pending,
  output logic        seq_busy
);

  // bus sequencer copy
  logic        active, failed;
  logic [2:0]  prog;
  logic [3:0]  phase, bit_count;
  logic [7:0]  shift_byte, bytes_left, poll_count;
  logic [7:0]  c_dev, c_reg, c_wd;
  logic [16:0] delay_count;
  logic        scl_l, sda_l;
  logic [7:0]  rx_b;
  logic        rx_v, rx_l;
  logic [7:0]  ack_timeout;
  logic [15:0] post_write_wait, post_cmd_wait;
  logic [16:0] pointer_read_wait;

  res_t expected_words[$];

  function automatic op_t op_at(logic [2:0] p, logic [3:0] ph);
    logic [47:0] seq;
    case (p)
      3'd0: seq = 48'h000A96574621;
      3'd1: seq = 48'h009873174621;
      3'd2: seq = 48'h098731B74621;
      3'd3: seq = 48'h00000C974621;
      3'd4: seq = 48'h000000C98631;
      3'd5: seq = 48'h000000000009;
      default: seq = '0;
    endcase
    if (ph >= PROG_LEN) return OP_END;
    return op_t'(seq[ph*4 +: 4]);
  endfunction

  // set up the current step, skipping empty ones; 1 when the sequence is over
  function automatic logic enter_op();
    op_t op;
    logic [16:0] w;
    for (int n = 0; n < 16; n++) begin
      op = op_at(prog, phase);
      delay_count = '0; bit_count = '0; poll_count = '0;
      if (op == OP_END) return 1'b1;
      if (op == OP_SEND_DEV) shift_byte = c_dev;
      if (op == OP_SEND_DEVR) shift_byte = c_dev + 8'd1;
      if (op == OP_SEND_REG) shift_byte = c_reg;
      if (op == OP_SEND_DATA) shift_byte = c_wd;
      if (op == OP_WAIT_W || op == OP_WAIT_P || op == OP_WAIT_C) begin
        w = (op == OP_WAIT_W) ? 17'(post_write_wait) :
            (op == OP_WAIT_P) ? pointer_read_wait : 17'(post_cmd_wait);
        if (w == 0) begin
          phase++;
          continue;
        end
        delay_count = w;
      end
      if (op == OP_READ && bytes_left == 0) begin
        phase++;
        continue;
      end
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // one tick: 0 go on, 1 step finished, 2 acknowledge missed
  function automatic int tick_op(op_t op, logic sda);
    logic [16:0] t;
    t = delay_count;
    case (op)
      OP_START: begin
        scl_l = 1'b1; sda_l = (t < 4);
        if (t >= 7) return 1;
        delay_count = t + 17'd1; return 0;
      end
      OP_SEND_DEV, OP_SEND_DEVR, OP_SEND_REG, OP_SEND_DATA: begin
        sda_l = shift_byte[7];
        scl_l = (t == 2 || t == 3);
        if (t >= 5) begin
          shift_byte = shift_byte << 1;
          bit_count++; delay_count = '0;
          return (bit_count >= 8) ? 1 : 0;
        end
        delay_count = t + 17'd1; return 0;
      end
      OP_ACK, OP_ACK_IGN: begin
        sda_l = 1'b1; scl_l = (t != 0);
        if (t < 2) begin
          delay_count = t + 17'd1; return 0;
        end
        if (!sda) return 1;
        if (poll_count >= ack_timeout) return (op == OP_ACK) ? 2 : 1;
        poll_count++; return 0;
      end
      OP_READ: begin
        if (bit_count < 8) begin
          sda_l = 1'b1;
          if (t < 2) begin
            scl_l = 1'b0; delay_count = t + 17'd1; return 0;
          end
          scl_l = 1'b1;
          shift_byte = {shift_byte[6:0], sda};
          bit_count++; delay_count = '0;
          if (bit_count >= 8) begin
            rx_b = shift_byte; rx_v = 1'b1; rx_l = (bytes_left == 1);
          end
          return 0;
        end
        // master acknowledge, nack on the last byte
        sda_l = !(bytes_left > 1);
        scl_l = (t >= 2);
        if (t < 3) begin
          delay_count = t + 17'd1; return 0;
        end
        bytes_left--; bit_count = '0; delay_count = '0; shift_byte = '0;
        return (bytes_left == 0) ? 1 : 0;
      end
      OP_STOP: begin
        scl_l = (t >= 4); sda_l = (t >= 5);
        if (t >= 8) return 1;
        delay_count = t + 17'd1; return 0;
      end
      default: begin
        if (delay_count > 0) delay_count--;
        return (delay_count == 0) ? 1 : 0;
      end
    endcase
  endfunction

  function automatic res_t next_levels();
    res_t r;
    op_t op;
    int code;
    logic done;
    done = 1'b0;
    rx_b = '0; rx_v = 1'b0; rx_l = 1'b0;
    if (req_type) begin
      if (!active && kind <= 3'd4) begin
        c_dev = dev_addr; c_reg = reg_addr; c_wd = wdata;
        prog = kind; phase = '0; failed = 1'b0;
        bytes_left = (kind == 3'd1) ? 8'd1 : length;
        active = !enter_op();
      end
    end else if (active) begin
      op = op_at(prog, phase);
      code = (op == OP_END) ? 1 : tick_op(op, sda_in);
      if (code == 2) begin
        failed = 1'b1; prog = PROG_ABORT; phase = '0;
        if (enter_op()) begin
          active = 1'b0; done = 1'b1;
        end
      end else if (code == 1) begin
        phase++;
        if (enter_op()) begin
          active = 1'b0; done = 1'b1;
        end
      end
    end
    r.scl = scl_l; r.sda_out = sda_l;
    r.rx_byte = rx_b; r.rx_valid = rx_v; r.rx_last = rx_l;
    r.done_res = done; r.status = done && failed; r.busy_res = active;
    return r;
  endfunction

  task automatic report(string field, logic [7:0] got, logic [7:0] want);
    $display("mismatch %s: got %0h expected %0h", field, got, want);
    failures++;
  endtask

  initial failures = 0;

  always @(posedge clk) begin
    res_t e;
    if (rst) begin
      active = 1'b0; failed = 1'b0; prog = '0; phase = '0; bit_count = '0;
      shift_byte = '0; bytes_left = '0; poll_count = '0; delay_count = '0;
      c_dev = '0; c_reg = '0; c_wd = '0; scl_l = 1'b1; sda_l = 1'b1;
      ack_timeout = 8'd250; post_write_wait = 16'd200;
      pointer_read_wait = 17'd100000; post_cmd_wait = 16'd5000;
      expected_words.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ACK_TIMEOUT: ack_timeout = cfg_data[7:0];
          CFG_POST_WRITE:  post_write_wait = cfg_data[15:0];
          CFG_PTR_READ:    pointer_read_wait = cfg_data;
          CFG_POST_CMD:    post_cmd_wait = cfg_data[15:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          report("unexpected word", 8'd1, 8'd0);
        end else begin
          e = expected_words.pop_front();
          if (scl !== e.scl) report("scl", 8'(scl), 8'(e.scl));
          if (sda_out !== e.sda_out) report("sda_out", 8'(sda_out), 8'(e.sda_out));
          if (rx_byte !== e.rx_byte) report("rx_byte", rx_byte, e.rx_byte);
          if (rx_valid !== e.rx_valid) report("rx_valid", 8'(rx_valid), 8'(e.rx_valid));
          if (rx_last !== e.rx_last) report("rx_last", 8'(rx_last), 8'(e.rx_last));
          if (done_res !== e.done_res) report("done_res", 8'(done_res), 8'(e.done_res));
          if (status !== e.status) report("status", 8'(status), 8'(e.status));
          if (busy_res !== e.busy_res) report("busy_res", 8'(busy_res), 8'(e.busy_res));
        end
      end
      if (in_valid && !in_stall) expected_words.push_back(next_levels());
    end
    pending <= expected_words.size();
    seq_busy <= active;
  end

endmodule

// ----- test/i2c_register_access_master_test.sv -----
`timescale 1ns / 1ps

module i2c_register_access_master_test import i2cram_pkg::*;;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        req_type = 1'b0;
  logic [2:0]  kind = '0;
  logic [7:0]  dev_addr = '0, reg_addr = '0, wdata = '0, length = '0;
  logic        sda_in = 1'b1;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        scl, sda_out, rx_valid, rx_last, done_res, status, busy_res;
  logic [7:0]  rx_byte;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [16:0] cfg_data = '0;

  int   failures, pending;
  logic seq_busy;
  int   words_sent;
  int   hold_req = 0, hold_done = 0;
  logic quiet = 1'b0;   // no idling on either side while set
  int   idle_cycles = 0;

  always #4 clk = ~clk;

  i2c_register_access_master uut (.*);

  i2c_register_access_master_check chk (.*);

  // random gap length: mostly none or short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // offer one word and hold it until the block takes it
  task automatic send_word(logic rt, logic [2:0] k, logic [7:0] da, logic [7:0] ra,
                           logic [7:0] wd, logic [7:0] len, logic sda);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rt; kind <= k; dev_addr <= da; reg_addr <= ra;
    wdata <= wd; length <= len; sda_in <= sda;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  task automatic tick(logic sda);
    send_word(1'b0, 3'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
              8'($urandom), sda);
  endtask

  // a command and the ticks that carry it to the end; nack holds the line high
  task automatic run_txn(logic [2:0] k, logic [7:0] da, logic [7:0] ra, logic [7:0] wd,
                         logic [7:0] len, logic nack, logic noise);
    send_word(1'b1, k, da, ra, wd, len, 1'($urandom));
    do begin
      if (noise && $urandom_range(0, 99) < 3)
        // command while busy, must be dropped
        send_word(1'b1, 3'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom), 1'($urandom));
      else
        tick(nack ? 1'b1 : 1'(($urandom)));
    end while (seq_busy);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0 || seq_busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(logic [1:0] idx, logic [16:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_all(logic [7:0] to, logic [15:0] pw, logic [16:0] pr, logic [15:0] pc);
    settle();
    set_reg(CFG_ACK_TIMEOUT, 17'(to));
    set_reg(CFG_POST_WRITE, 17'(pw));
    set_reg(CFG_PTR_READ, pr);
    set_reg(CFG_POST_CMD, 17'(pc));
  endtask

  task automatic random_phase(int target);
    logic [2:0] k;
    logic [7:0] len;
    int r;
    words_sent = 0;
    while (words_sent < target) begin
      r = $urandom_range(0, 99);
      // most commands are real transactions, the rest bad kinds
      k = (r < 90) ? 3'($urandom_range(0, 4)) : 3'($urandom_range(5, 7));
      r = $urandom_range(0, 99);
      len = (r < 80) ? 8'($urandom_range(0, 3)) :
            (r < 97) ? 8'($urandom_range(4, 20)) : 8'($urandom);
      if ($urandom_range(0, 9) == 0) quiet = ~quiet;
      if ($urandom_range(0, 9) == 0) tick(1'($urandom));   // stray idle tick
      run_txn(k, 8'($urandom), 8'($urandom), 8'($urandom), len,
              $urandom_range(0, 99) < 15, 1'b1);
    end
    quiet = 1'b0;
  endtask

  // receiver: random stalls, plus the long hold-off when asked
  initial begin
    int n;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req != hold_done) begin
        out_stall <= 1'b1;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        hold_done++;
      end
      n = gap_len();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, reset settings: idle ticks, ignored kinds, address wrap, full nack poll
    tick(1'b0);
    tick(1'b1);
    send_word(1'b1, 3'd5, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1);
    send_word(1'b1, 3'd7, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    run_txn(3'd1, 8'hff, 8'h00, 8'hff, 8'h00, 1'b0, 1'b0);
    run_txn(3'd0, 8'h00, 8'hff, 8'h00, 8'hff, 1'b1, 1'b0);

    // zero timeout and zero waits: misses everywhere, empty waits
    set_all(8'd0, 16'd0, 17'd0, 16'd0);
    run_txn(3'd4, 8'h81, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
    run_txn(3'd2, 8'h40, 8'h80, 8'h00, 8'd2, 1'b0, 1'b0);
    random_phase(90);

    // short waits; the receiver holds off while ticks keep coming
    set_all(8'd3, 16'd5, 17'd17, 16'd9);
    hold_req++;
    random_phase(90);

    // longest timeout; write and command waits of one tick, pointer wait of two
    set_all(8'd255, 16'd1, 17'd2, 16'd1);
    random_phase(90);

    settle();
    repeat (16) @(posedge clk);
    if (failures == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
